@@ hdl/att_pkg.sv @@
// Shared types, character codes and colour helpers for the text terminal engine.
package att_pkg;

  localparam int ROW_W  = 6;
  localparam int COL_W  = 8;
  localparam int PROD_W = ROW_W + COL_W;
  localparam int CELL_W = 16;

  localparam logic [7:0]  BASE_ATTR  = 8'h0f;
  localparam logic [7:0]  BLANK_CHAR = 8'h20;
  localparam logic [CELL_W-1:0] BLANK_CELL = {BASE_ATTR, BLANK_CHAR};

  localparam logic [7:0] CH_BS     = 8'd8;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_ESC    = 8'd27;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_QMARK  = 8'h3f;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CMD_CUP   = 8'h48;  // H
  localparam logic [7:0] CMD_HVP   = 8'h66;  // f
  localparam logic [7:0] CMD_ED    = 8'h4a;  // J
  localparam logic [7:0] CMD_EL    = 8'h4b;  // K
  localparam logic [7:0] CMD_CUU   = 8'h41;  // A
  localparam logic [7:0] CMD_CUD   = 8'h42;  // B
  localparam logic [7:0] CMD_CUF   = 8'h43;  // C
  localparam logic [7:0] CMD_CUB   = 8'h44;  // D
  localparam logic [7:0] CMD_SGR   = 8'h6d;  // m

  localparam logic [7:0] BOLD_SET  = 8'h08;
  localparam logic [7:0] BOLD_KEEP = 8'hf7;

  localparam logic [15:0] SGR_RESET   = 16'd0;
  localparam logic [15:0] SGR_BOLD    = 16'd1;
  localparam logic [15:0] SGR_NORMAL  = 16'd22;
  localparam logic [15:0] SGR_REVERSE = 16'd7;
  localparam logic [15:0] SGR_FG_LO   = 16'd30;
  localparam logic [15:0] SGR_FG_HI   = 16'd37;
  localparam logic [15:0] SGR_FG_DEF  = 16'd39;
  localparam logic [15:0] SGR_BG_LO   = 16'd40;
  localparam logic [15:0] SGR_BG_HI   = 16'd47;
  localparam logic [15:0] SGR_BFG_LO  = 16'd90;
  localparam logic [15:0] SGR_BFG_HI  = 16'd97;
  localparam logic [15:0] SGR_BBG_LO  = 16'd100;
  localparam logic [15:0] SGR_BBG_HI  = 16'd107;
  localparam logic [15:0] ED_ALL      = 16'd2;

  localparam logic CFG_COLUMNS = 1'b0;
  localparam logic CFG_ROWS    = 1'b1;

  typedef enum logic [1:0] {
    KIND_TERM  = 2'd0,
    KIND_RAW   = 2'd1,
    KIND_READ  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ESC  = 2'd1,
    PH_CSI  = 2'd2
  } phase_t;

  typedef struct packed {
    logic       clear;
    logic       digit;
    logic [3:0] digit_val;
    logic       advance;
    logic       shift;
  } csi_cmd_t;

  typedef struct packed {
    logic [15:0] v0;
    logic [15:0] v1;
    logic        v1_live;
  } csi_args_t;

  function automatic logic [2:0] sgr_to_vga(input logic [2:0] idx);
    logic [2:0] res;
    case (idx)
      3'd0:    res = 3'd0;
      3'd1:    res = 3'd4;
      3'd2:    res = 3'd2;
      3'd3:    res = 3'd6;
      3'd4:    res = 3'd1;
      3'd5:    res = 3'd5;
      3'd6:    res = 3'd3;
      default: res = 3'd7;
    endcase
    return res;
  endfunction

  function automatic logic [7:0] apply_sgr(input logic [15:0] p, input logic [7:0] a);
    logic [7:0] res;
    logic [15:0] off;
    res = a;
    off = 16'd0;
    if (p == SGR_RESET) begin
      res = BASE_ATTR;
    end else if (p == SGR_BOLD) begin
      res = a | BOLD_SET;
    end else if (p == SGR_NORMAL) begin
      res = a & BOLD_KEEP;
    end else if (p == SGR_REVERSE) begin
      res = {a[3:0], a[7:4]};
    end else if (p >= SGR_FG_LO && p <= SGR_FG_HI) begin
      off = p - SGR_FG_LO;
      res = {a[7:3], sgr_to_vga(off[2:0])};
    end else if (p == SGR_FG_DEF) begin
      res = {a[7:4], BASE_ATTR[3:0]};
    end else if (p >= SGR_BG_LO && p <= SGR_BG_HI) begin
      off = p - SGR_BG_LO;
      res = {1'b0, sgr_to_vga(off[2:0]), a[3:0]};
    end else if (p >= SGR_BFG_LO && p <= SGR_BFG_HI) begin
      off = p - SGR_BFG_LO;
      res = {a[7:4], 1'b1, sgr_to_vga(off[2:0])};
    end else if (p >= SGR_BBG_LO && p <= SGR_BBG_HI) begin
      off = p - SGR_BBG_LO;
      res = {1'b1, sgr_to_vga(off[2:0]), a[3:0]};
    end
    return res;
  endfunction

endpackage

@@ hdl/att_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module att_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 9600,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/att_csi.sv @@
// CSI parameter registers: decimal accumulation, slot select and shift-out.
module att_csi #(
  parameter int SLOTS  = 3,
  parameter int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  att_pkg::csi_cmd_t   cmd_i,
  output att_pkg::csi_args_t  args_o,
  output logic [SLOT_W-1:0]   slot_o
);
  import att_pkg::*;

  localparam int IDX1 = (SLOTS > 1) ? 1 : 0;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

  logic [15:0]       val_r   [SLOTS];
  logic [15:0]       val_nxt [SLOTS];
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [19:0]       acc;

  assign acc = 20'(val_r[slot_r]) * 20'd10 + 20'(cmd_i.digit_val);

  always_comb begin
    val_nxt  = val_r;
    slot_nxt = slot_r;
    if (cmd_i.clear) begin
      for (int i = 0; i < SLOTS; i++) val_nxt[i] = 16'd0;
      slot_nxt = '0;
    end else if (cmd_i.digit) begin
      val_nxt[slot_r] = (acc > 20'd65535) ? 16'hffff : acc[15:0];
    end else if (cmd_i.advance) begin
      if (slot_r != LAST_SLOT) slot_nxt = slot_r + 1'b1;
    end else if (cmd_i.shift) begin
      for (int i = 0; i < SLOTS - 1; i++) val_nxt[i] = val_r[i+1];
      val_nxt[SLOTS-1] = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) val_r[i] <= 16'd0;
      slot_r <= '0;
    end else begin
      val_r  <= val_nxt;
      slot_r <= slot_nxt;
    end
  end

  assign args_o.v0      = val_r[0];
  assign args_o.v1      = val_r[IDX1];
  assign args_o.v1_live = (SLOTS > 1) && (slot_r != '0);
  assign slot_o         = slot_r;

endmodule

@@ hdl/ansi_text_terminal_engine.sv @@
// Top level of the ANSI text terminal engine: sequencer around the cell store.
// A printable byte, control byte or parser byte is handled in ST_EXEC; an on-screen cell read also passes ST_READ.
// SGR applies its parameter slots one at a time in ST_SGR; clear, J2 and K blank one cell at a time in ST_FILL.
// A scroll reads then writes each copied cell in ST_COPY_RD and ST_COPY_WR (one RAM read port), then blanks in ST_FILL.
// One item at a time; the next is taken once the result is in the output register.
// Reset (sync, active low) starts a clearing pass over all MAX_COLUMNS*MAX_ROWS cells, no items taken.
module ansi_text_terminal_engine #(
  parameter int MAX_COLUMNS     = 160,
  parameter int MAX_ROWS        = 60,
  parameter int CSI_VALUE_SLOTS = 3
) (
  input  logic       clk,
  input  logic       rst_n,
  // item input
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_char_code,
  input  logic [7:0] in_raw_color,
  input  logic [5:0] in_read_row,
  input  logic [7:0] in_read_column,
  // result output
  output logic       out_valid,
  input  logic       out_ready,
  output logic [5:0] out_cur_row,
  output logic [7:0] out_cur_col,
  output logic [7:0] out_text_color,
  output logic [1:0] out_escape_phase,
  output logic [7:0] out_cell_char,
  output logic [7:0] out_cell_color,
  // configuration writes
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);
  import att_pkg::*;

  localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
  localparam int AW     = $clog2(DEPTH);
  localparam int SLOT_W = (CSI_VALUE_SLOTS > 1) ? $clog2(CSI_VALUE_SLOTS) : 1;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_EXEC, ST_READ, ST_COPY_RD, ST_COPY_WR, ST_FILL, ST_SGR, ST_DONE
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [7:0] cols_cfg_r;
  logic [5:0] rows_cfg_r;
  logic [7:0] w;
  logic [5:0] h;

  // captured item
  kind_t      kind_r;
  logic [7:0] char_r, rawc_r, rcol_r;
  logic [5:0] rrow_r;

  // terminal state
  logic [5:0]  row_r, row_nxt;
  logic [7:0]  col_r, col_nxt;
  logic [7:0]  attr_r, attr_nxt;
  phase_t      phase_r, phase_nxt;
  logic [7:0]  cell_ch_nxt, cell_at_nxt;
  logic [7:0]  cell_ch_r, cell_at_r;

  // sweep control
  logic [PROD_W-1:0] ptr_r, ptr_nxt, end_r, end_nxt;
  logic [AW-1:0]     init_ptr_r;
  logic [SLOT_W-1:0] sgr_cnt_r, sgr_cnt_nxt;

  // output register
  logic       out_valid_r;
  logic [5:0] out_row_r;
  logic [7:0] out_col_r, out_attr_r, out_ch_r, out_at_r;
  logic [1:0] out_phase_r;

  // RAM ports
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  // CSI
  csi_cmd_t          csi_cmd;
  csi_args_t         csi_args;
  logic [SLOT_W-1:0] csi_slot;
  logic [15:0]       arg0, arg1;

  // address arithmetic
  logic [5:0]        mul_row;
  logic [7:0]        col_op;
  logic [PROD_W-1:0] prod, area, cell_addr;

  logic accept, slot_free, finish, out_load;
  logic do_emit, lf_req, on_screen;
  logic [7:0]  emit_attr;
  logic [16:0] sum_row, sum_col;

  att_csi #(.SLOTS(CSI_VALUE_SLOTS), .SLOT_W(SLOT_W)) u_csi (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd_i  (csi_cmd),
    .args_o (csi_args),
    .slot_o (csi_slot)
  );

  att_ram #(.WIDTH(CELL_W), .DEPTH(DEPTH), .ADDR_W(AW)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Screen size in use, with out-of-range register values clamped
  always_comb begin
    if (cols_cfg_r == 8'd0) w = 8'd1;
    else if (int'(cols_cfg_r) > MAX_COLUMNS) w = 8'(MAX_COLUMNS);
    else w = cols_cfg_r;
    if (rows_cfg_r == 6'd0) h = 6'd1;
    else if (int'(rows_cfg_r) > MAX_ROWS) h = 6'(MAX_ROWS);
    else h = rows_cfg_r;
  end

  assign arg0 = (csi_args.v0 == 16'd0) ? 16'd1 : csi_args.v0;
  assign arg1 = (csi_args.v1_live && csi_args.v1 != 16'd0) ? csi_args.v1 : 16'd1;

  // One multiplier for the cell address (cursor or read position), one for the area.
  // Backspace blanks the cell left of the cursor.
  assign mul_row   = (kind_r == KIND_READ) ? rrow_r : row_r;
  assign col_op    = (kind_r == KIND_READ) ? rcol_r :
                     (char_r == CH_BS)     ? col_r - 8'd1 : col_r;
  assign prod      = PROD_W'(mul_row) * PROD_W'(w);
  assign area      = PROD_W'(h) * PROD_W'(w);
  assign cell_addr = prod + PROD_W'(col_op);
  assign on_screen = (row_r < h) && (col_r < w);
  assign sum_row   = 17'(row_r) + 17'(arg0);
  assign sum_col   = 17'(col_r) + 17'(arg0);

  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);

  always_comb begin
    state_nxt   = state_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    attr_nxt    = attr_r;
    phase_nxt   = phase_r;
    cell_ch_nxt = cell_ch_r;
    cell_at_nxt = cell_at_r;
    ptr_nxt     = ptr_r;
    end_nxt     = end_r;
    sgr_cnt_nxt = sgr_cnt_r;
    csi_cmd     = '0;
    ram_we      = 1'b0;
    ram_waddr   = AW'(cell_addr);
    ram_wdata   = BLANK_CELL;
    ram_raddr   = AW'(cell_addr);
    finish      = 1'b0;
    do_emit     = 1'b0;
    lf_req      = 1'b0;
    emit_attr   = attr_r;

    unique case (state_r)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = init_ptr_r;
        if (int'(init_ptr_r) == DEPTH - 1) state_nxt = ST_IDLE;
      end

      ST_IDLE: begin
        if (accept) state_nxt = ST_EXEC;
      end

      ST_EXEC: begin
        cell_ch_nxt = 8'd0;
        cell_at_nxt = 8'd0;
        finish      = 1'b1;
        unique case (kind_r)
          KIND_TERM: begin
            unique case (phase_r)
              PH_IDLE: begin
                if (char_r == CH_ESC) phase_nxt = PH_ESC;
                else do_emit = 1'b1;
              end
              PH_ESC: begin
                if (char_r == CH_LBRACK) begin
                  phase_nxt = PH_CSI;
                end else begin
                  phase_nxt     = PH_IDLE;
                  csi_cmd.clear = 1'b1;
                  do_emit       = 1'b1;
                end
              end
              default: begin
                if (char_r == CH_QMARK) begin
                  // private marker: no effect on the supported commands
                end else if (char_r >= CH_0 && char_r <= CH_9) begin
                  csi_cmd.digit     = 1'b1;
                  csi_cmd.digit_val = 4'(char_r - CH_0);
                end else if (char_r == CH_SEMI) begin
                  csi_cmd.advance = 1'b1;
                end else begin
                  // final byte
                  phase_nxt     = PH_IDLE;
                  csi_cmd.clear = 1'b1;
                  if (char_r == CMD_CUP || char_r == CMD_HVP) begin
                    row_nxt = (arg0 > 16'(h)) ? h - 6'd1 : 6'(arg0 - 16'd1);
                    col_nxt = (arg1 > 16'(w)) ? w - 8'd1 : 8'(arg1 - 16'd1);
                  end else if (char_r == CMD_ED && csi_args.v0 == ED_ALL) begin
                    row_nxt   = 6'd0;
                    col_nxt   = 8'd0;
                    ptr_nxt   = '0;
                    end_nxt   = area;
                    finish    = 1'b0;
                    state_nxt = ST_FILL;
                  end else if (char_r == CMD_EL) begin
                    if (on_screen) begin
                      ptr_nxt   = cell_addr;
                      end_nxt   = prod + PROD_W'(w);
                      finish    = 1'b0;
                      state_nxt = ST_FILL;
                    end
                  end else if (char_r == CMD_CUU) begin
                    row_nxt = (arg0 > 16'(row_r)) ? 6'd0 : row_r - 6'(arg0);
                  end else if (char_r == CMD_CUD) begin
                    row_nxt = (sum_row >= 17'(h)) ? h - 6'd1 : 6'(sum_row);
                  end else if (char_r == CMD_CUF) begin
                    col_nxt = (sum_col >= 17'(w)) ? w - 8'd1 : 8'(sum_col);
                  end else if (char_r == CMD_CUB) begin
                    col_nxt = (arg0 > 16'(col_r)) ? 8'd0 : col_r - 8'(arg0);
                  end else if (char_r == CMD_SGR) begin
                    // parameters are applied one per cycle, parser cleared at the end
                    phase_nxt     = phase_r;
                    csi_cmd.clear = 1'b0;
                    sgr_cnt_nxt   = csi_slot;
                    finish        = 1'b0;
                    state_nxt     = ST_SGR;
                  end
                end
              end
            endcase
          end
          KIND_RAW: begin
            do_emit   = 1'b1;
            emit_attr = rawc_r;
          end
          KIND_READ: begin
            if (rrow_r < h && rcol_r < w) begin
              finish    = 1'b0;
              state_nxt = ST_READ;
            end
          end
          default: begin
            row_nxt       = 6'd0;
            col_nxt       = 8'd0;
            attr_nxt      = BASE_ATTR;
            phase_nxt     = PH_IDLE;
            csi_cmd.clear = 1'b1;
            ptr_nxt       = '0;
            end_nxt       = area;
            finish        = 1'b0;
            state_nxt     = ST_FILL;
          end
        endcase

        if (do_emit) begin
          if (char_r == CH_BS) begin
            if (col_r != 8'd0) begin
              col_nxt = col_r - 8'd1;
              ram_we  = (row_r < h) && (col_r - 8'd1 < w);
            end
          end else if (char_r == CH_CR) begin
            col_nxt = 8'd0;
          end else if (char_r == CH_LF) begin
            lf_req = 1'b1;
          end else begin
            ram_we    = on_screen;
            ram_wdata = {emit_attr, char_r};
            if (9'(col_r) + 9'd1 >= 9'(w)) lf_req = 1'b1;
            else col_nxt = col_r + 8'd1;
          end
        end

        if (lf_req) begin
          col_nxt = 8'd0;
          if (7'(row_r) + 7'd1 >= 7'(h)) begin
            // scroll: copy rows up, then blank the bottom row
            row_nxt = h - 6'd1;
            end_nxt = area;
            finish  = 1'b0;
            if (h > 6'd1) begin
              ptr_nxt   = PROD_W'(w);
              state_nxt = ST_COPY_RD;
            end else begin
              ptr_nxt   = area - PROD_W'(w);
              state_nxt = ST_FILL;
            end
          end else begin
            row_nxt = row_r + 6'd1;
          end
        end
      end

      ST_READ: begin
        cell_ch_nxt = ram_rdata[7:0];
        cell_at_nxt = ram_rdata[15:8];
        finish      = 1'b1;
      end

      ST_COPY_RD: begin
        ram_raddr = AW'(ptr_r);
        state_nxt = ST_COPY_WR;
      end

      ST_COPY_WR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(ptr_r - PROD_W'(w));
        ram_wdata = ram_rdata;
        if (ptr_r + 1'b1 == end_r) begin
          ptr_nxt   = area - PROD_W'(w);
          state_nxt = ST_FILL;
        end else begin
          ptr_nxt   = ptr_r + 1'b1;
          state_nxt = ST_COPY_RD;
        end
      end

      ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(ptr_r);
        ptr_nxt   = ptr_r + 1'b1;
        if (ptr_r + 1'b1 == end_r) finish = 1'b1;
      end

      ST_SGR: begin
        attr_nxt      = apply_sgr(csi_args.v0, attr_r);
        csi_cmd.shift = 1'b1;
        if (sgr_cnt_r == '0) begin
          csi_cmd.clear = 1'b1;
          phase_nxt     = PH_IDLE;
          finish        = 1'b1;
        end else begin
          sgr_cnt_nxt = sgr_cnt_r - 1'b1;
        end
      end

      ST_DONE: begin
        finish = 1'b1;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // hand the result over, or park it until the output register frees up
    if (finish) state_nxt = slot_free ? ST_IDLE : ST_DONE;
  end

  assign out_load = finish && slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      init_ptr_r  <= '0;
      cols_cfg_r  <= 8'd80;
      rows_cfg_r  <= 6'd20;
      row_r       <= 6'd0;
      col_r       <= 8'd0;
      attr_r      <= BASE_ATTR;
      phase_r     <= PH_IDLE;
      ptr_r       <= '0;
      end_r       <= '0;
      sgr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      row_r     <= row_nxt;
      col_r     <= col_nxt;
      attr_r    <= attr_nxt;
      phase_r   <= phase_nxt;
      ptr_r     <= ptr_nxt;
      end_r     <= end_nxt;
      sgr_cnt_r <= sgr_cnt_nxt;
      if (state_r == ST_INIT) init_ptr_r <= init_ptr_r + 1'b1;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_COLUMNS: cols_cfg_r <= cfg_data;
          CFG_ROWS:    rows_cfg_r <= cfg_data[5:0];
          default:     cols_cfg_r <= cols_cfg_r;
        endcase
      end

      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cell_ch_r <= cell_ch_nxt;
    cell_at_r <= cell_at_nxt;
    if (accept) begin
      kind_r <= kind_t'(in_kind);
      char_r <= in_char_code;
      rawc_r <= in_raw_color;
      rrow_r <= in_read_row;
      rcol_r <= in_read_column;
    end
    if (out_load) begin
      out_row_r   <= row_nxt;
      out_col_r   <= col_nxt;
      out_attr_r  <= attr_nxt;
      out_phase_r <= phase_nxt;
      out_ch_r    <= cell_ch_nxt;
      out_at_r    <= cell_at_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_cur_row      = out_row_r;
  assign out_cur_col      = out_col_r;
  assign out_text_color   = out_attr_r;
  assign out_escape_phase = out_phase_r;
  assign out_cell_char    = out_ch_r;
  assign out_cell_color   = out_at_r;

`ifndef SYNTHESIS
  // no item slips in during the clearing pass
  a_init_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_INIT |-> !in_ready)
    else $error("item ready during clearing pass");

  // sweep pointer stays inside its range
  a_sweep_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL || state_r == ST_COPY_WR) |-> ptr_r < end_r)
    else $error("sweep pointer past end");

  // store writes after the clearing pass stay inside the screen area
  a_write_area: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && state_r != ST_INIT) |-> ram_waddr < AW'(area))
    else $error("cell write outside screen area");

  // one item at a time: an accepted item is worked on before the next
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_EXEC && !in_ready)
    else $error("second item accepted while busy");
`endif

endmodule
